>>> hdl/swarmalator_pairwise_rates_unit_defines.svh
// Assertion macros for the swarmalator pairwise rates unit.
// Included by the top level; needs no other file.
`ifndef SWARMALATOR_PAIRWISE_RATES_UNIT_DEFINES_SVH
`define SWARMALATOR_PAIRWISE_RATES_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWPR_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swpr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWPR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swpr: next-cycle check failed");

`endif

>>> hdl/swpr_pkg.sv
// Shared widths, codes, sine polynomial constants and helpers for the
// swarmalator pairwise rates unit. Has no dependencies.
package swpr_pkg;

  localparam int MAX_OSC = 64;
  localparam int IDX_W   = $clog2(MAX_OSC);
  localparam int CNT_W   = $clog2(MAX_OSC + 1);

  localparam int POS_W   = 24;
  localparam int PH_W    = 16;
  localparam int VAL_W   = 32;
  localparam int CFG_W   = 2;
  localparam int RAM_W   = 2 * POS_W + PH_W;

  localparam int DIFF_W  = POS_W + 1;
  localparam int NORM2_W = 2 * DIFF_W;
  localparam int ROOT_W  = DIFF_W;
  localparam int NUM_W   = 64;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 64;
  localparam int POLY_W  = 17;
  localparam int TRIG_W  = POLY_W + 1;
  localparam int UNIT_W  = 18;
  localparam int WGT_W   = VAL_W + 1;
  localparam int FRAC_W  = 16;

  localparam logic [POLY_W-1:0] SIN_A = 17'd102944;
  localparam logic [POLY_W-1:0] SIN_B = 17'd42047;
  localparam logic [POLY_W-1:0] SIN_C = 17'd4639;
  localparam logic [PH_W-1:0]   QUARTER_TURN = 16'h4000;
  localparam logic [PH_W-2:0]   QUARTER_SPAN = 15'd16384;

  typedef enum logic [CFG_W-1:0] {
    CFG_ATTRACT  = 2'd0,
    CFG_COUPLING = 2'd1,
    CFG_REPULSE  = 2'd2,
    CFG_SYNC     = 2'd3
  } cfg_reg_t;

  typedef enum logic [5:0] {
    ST_LOAD, ST_SELF_RD, ST_SELF_CAP, ST_PAIR_RD, ST_PAIR_DX,
    ST_SQ_X, ST_SQ_Y, ST_NORM2, ST_CHECK, ST_SQRT,
    ST_TRIG_Z, ST_TRIG_C, ST_TRIG_B, ST_TRIG_A, ST_TRIG_END,
    ST_W_MUL, ST_W_SUM,
    ST_DIV_UX, ST_DIV_UY, ST_DIV_RX, ST_DIV_RY, ST_DIV_PH,
    ST_M_UXW, ST_M_RX, ST_M_UYW, ST_M_RY, ST_M_END,
    ST_DIV_MX, ST_DIV_MY, ST_DIV_MP, ST_SYNC_MUL, ST_SYNC_END, ST_PUT
  } st_t;

  function automatic logic signed [VAL_W-1:0] clamp32(input logic signed [NUM_W-1:0] v);
    logic signed [NUM_W-1:0] hi;
    logic signed [NUM_W-1:0] lo;
    hi = NUM_W'($signed({1'b0, {(VAL_W-1){1'b1}}}));
    lo = NUM_W'($signed({1'b1, {(VAL_W-1){1'b0}}}));
    if (v > hi) begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return v[VAL_W-1:0];
    end
  endfunction

endpackage

>>> hdl/swpr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Has no dependencies.
module swpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/swpr_div.sv
// Sequential signed-by-positive divider, one quotient bit per cycle,
// truncating toward zero. Depends on swpr_pkg.
module swpr_div import swpr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [NUM_W-1:0]  dividend,
  input  logic [NORM2_W-1:0]       divisor,
  output logic                     busy,
  output logic                     done,
  output logic signed [NUM_W-1:0]  quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]   quo;
  logic [NORM2_W-1:0] rem;
  logic [NORM2_W-1:0] den;
  logic [STEP_W-1:0]  steps;
  logic               neg;
  logic [NORM2_W:0]   rem_sh;
  logic [NORM2_W:0]   diff;

  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign diff     = rem_sh - {1'b0, den};
  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= dividend[NUM_W-1];
      quo   <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
      rem   <= '0;
      den   <= divisor;
      steps <= STEP_W'(NUM_W);
    end else if (busy) begin
      // The remainder stays below twice the divisor, so the top bit is the borrow.
      if (!diff[NORM2_W]) begin
        rem <= diff[NORM2_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[NORM2_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
      steps <= steps - STEP_W'(1);
    end
  end

endmodule

>>> hdl/swpr_sqrt.sv
// Sequential integer square root, one root bit per cycle (floor result).
// Depends on swpr_pkg.
module swpr_sqrt import swpr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NORM2_W-1:0]  radicand,
  output logic                busy,
  output logic                done,
  output logic [ROOT_W-1:0]   root
);

  localparam int STEP_W = $clog2(ROOT_W + 1);
  localparam int REM_W  = ROOT_W + 2;
  localparam int CMP_W  = ROOT_W + 4;

  logic [NORM2_W-1:0] rad;
  logic [REM_W-1:0]   rem;
  logic [STEP_W-1:0]  steps;
  logic [CMP_W-1:0]   rem_sh;
  logic [CMP_W-1:0]   trial;
  logic [CMP_W-1:0]   diff;

  assign rem_sh = {rem, rad[NORM2_W-1 -: 2]};
  assign trial  = CMP_W'({root, 2'b01});
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && steps == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad   <= radicand;
      rem   <= '0;
      root  <= '0;
      steps <= STEP_W'(ROOT_W);
    end else if (busy) begin
      rad <= {rad[NORM2_W-3:0], 2'b00};
      if (!diff[CMP_W-1]) begin
        rem  <= diff[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[REM_W-1:0];
        root <= {root[ROOT_W-2:0], 1'b0};
      end
      steps <= steps - STEP_W'(1);
    end
  end

endmodule

>>> hdl/swarmalator_pairwise_rates_unit.sv
// Swarmalator all-pairs rate unit: load store, pair sequencer and output register.
// Depends on swpr_pkg, swpr_ram, swpr_div, swpr_sqrt and the assertion header.
//
// Usage: oscillators arrive one beat at a time on the in_ channel (position and
// phase); up to 64 are kept in a RAM and further beats are dropped. The beat with
// last_in set closes the set, after which in_ready stays low until the set has been
// worked through. One result beat per stored oscillator then leaves on out_, in
// load order, with last_out on the final one.
// Each result walks every other stored oscillator through a 64-step divider (five
// divisions per pair) and a 25-step square root.
// The output register lets the next result be worked on while one waits; if the
// receiver stalls, the sequencer holds at the point of handing over the next
// result. The last result is handed to the register before loading reopens.
// Configuration writes on cfg_ are always taken and must only occur while idle.
// Reset clears the gains to their defaults, empties the store and drops any
// pending result; RAM contents are left as they were.
`include "swarmalator_pairwise_rates_unit_defines.svh"

module swarmalator_pairwise_rates_unit import swpr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_W-1:0]         cfg_index,
  input  logic [VAL_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic [PH_W-1:0]          phase,
  input  logic                     last_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VAL_W-1:0]  vel_x,
  output logic signed [VAL_W-1:0]  vel_y,
  output logic signed [VAL_W-1:0]  phase_rate,
  output logic                     coincident,
  output logic                     last_out
);

  st_t state, state_next;

  logic signed [VAL_W-1:0] attract_gain, coupling_gain, repulse_gain, sync_gain;

  logic [CNT_W-1:0] load_cnt, set_n, j_cnt;
  logic [IDX_W-1:0] i_idx;

  logic signed [POS_W-1:0] self_x, self_y;
  logic [PH_W-1:0]         self_ph;
  logic signed [DIFF_W-1:0] dx, dy;
  logic [PH_W-1:0]          dphi;
  logic [NORM2_W-1:0]       norm2;
  logic [ROOT_W-1:0]        nr;

  logic                     trig_sel, trig_neg;
  logic [POLY_W-1:0]        z_reg, z2_reg;
  logic signed [TRIG_W-1:0] cos_v, sin_v;
  logic signed [WGT_W-1:0]  w;
  logic signed [UNIT_W-1:0] ux, uy;
  logic signed [VAL_W-1:0]  rx, ry, mx, my, mp, pr;
  logic signed [NUM_W-1:0]  sx, sy, sp, tx_a, ty_a;
  logic                     coin;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_full;
  logic signed [PROD_W-1:0]  prod, prod_sh;
  logic [POLY_W-1:0]         prod_hi;

  logic [PH_W-1:0]         angle;
  logic [PH_W-2:0]         quarter_u;
  logic [POLY_W-1:0]       z_comb;
  logic signed [TRIG_W-1:0] trig_val;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [RAM_W-1:0] ram_wdata, ram_rdata;
  logic signed [POS_W-1:0] rd_x, rd_y;
  logic [PH_W-1:0]         rd_ph;

  logic                    div_start, div_busy, div_done;
  logic signed [NUM_W-1:0] div_num, div_q;
  logic [NORM2_W-1:0]      div_den;
  logic                    sq_start, sq_busy, sq_done;
  logic [ROOT_W-1:0]       sq_root;

  logic in_acc, out_free, is_div, is_last_res, j_is_self, store_full;

  assign in_acc      = in_valid && in_ready;
  assign out_free    = !out_valid || out_ready;
  assign is_last_res = (CNT_W'(i_idx) + CNT_W'(1)) == set_n;
  assign j_is_self   = j_cnt == CNT_W'(i_idx);
  assign store_full  = load_cnt == CNT_W'(MAX_OSC);
  assign cfg_ready   = 1'b1;

  assign rd_x  = ram_rdata[RAM_W-1 -: POS_W];
  assign rd_y  = ram_rdata[PH_W +: POS_W];
  assign rd_ph = ram_rdata[PH_W-1:0];

  assign mul_full = mul_a * mul_b;
  assign prod_sh  = prod >>> FRAC_W;
  assign prod_hi  = prod[FRAC_W +: POLY_W];

  // Cosine is the sine a quarter turn on; the second quadrant bit gives the sign.
  assign angle     = trig_sel ? dphi : dphi + QUARTER_TURN;
  assign quarter_u = angle[PH_W-2] ? QUARTER_SPAN - {1'b0, angle[PH_W-3:0]}
                                   : {1'b0, angle[PH_W-3:0]};
  assign z_comb    = {quarter_u, 2'b00};
  assign trig_val  = trig_neg ? -$signed({1'b0, prod_hi}) : $signed({1'b0, prod_hi});

  swpr_ram #(.WIDTH(RAM_W), .DEPTH(MAX_OSC)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  swpr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  swpr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (norm2),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:     if (in_acc && last_in) state_next = ST_SELF_RD;
      ST_SELF_RD:  state_next = ST_SELF_CAP;
      ST_SELF_CAP: state_next = ST_PAIR_RD;
      ST_PAIR_RD: begin
        if (j_cnt >= set_n) begin
          state_next = ST_DIV_MX;
        end else if (!j_is_self) begin
          state_next = ST_PAIR_DX;
        end
      end
      ST_PAIR_DX:  state_next = ST_SQ_X;
      ST_SQ_X:     state_next = ST_SQ_Y;
      ST_SQ_Y:     state_next = ST_NORM2;
      ST_NORM2:    state_next = ST_CHECK;
      ST_CHECK:    state_next = (norm2 == '0) ? ST_PAIR_RD : ST_SQRT;
      ST_SQRT:     if (sq_done) state_next = ST_TRIG_Z;
      ST_TRIG_Z:   state_next = ST_TRIG_C;
      ST_TRIG_C:   state_next = ST_TRIG_B;
      ST_TRIG_B:   state_next = ST_TRIG_A;
      ST_TRIG_A:   state_next = ST_TRIG_END;
      ST_TRIG_END: state_next = trig_sel ? ST_W_MUL : ST_TRIG_Z;
      ST_W_MUL:    state_next = ST_W_SUM;
      ST_W_SUM:    state_next = ST_DIV_UX;
      ST_DIV_UX:   if (div_done) state_next = ST_DIV_UY;
      ST_DIV_UY:   if (div_done) state_next = ST_DIV_RX;
      ST_DIV_RX:   if (div_done) state_next = ST_DIV_RY;
      ST_DIV_RY:   if (div_done) state_next = ST_DIV_PH;
      ST_DIV_PH:   if (div_done) state_next = ST_M_UXW;
      ST_M_UXW:    state_next = ST_M_RX;
      ST_M_RX:     state_next = ST_M_UYW;
      ST_M_UYW:    state_next = ST_M_RY;
      ST_M_RY:     state_next = ST_M_END;
      ST_M_END:    state_next = ST_PAIR_RD;
      ST_DIV_MX:   if (div_done) state_next = ST_DIV_MY;
      ST_DIV_MY:   if (div_done) state_next = ST_DIV_MP;
      ST_DIV_MP:   if (div_done) state_next = ST_SYNC_MUL;
      ST_SYNC_MUL: state_next = ST_SYNC_END;
      ST_SYNC_END: state_next = ST_PUT;
      ST_PUT: begin
        if (out_free) begin
          state_next = is_last_res ? ST_LOAD : ST_SELF_RD;
        end
      end
      default:     state_next = ST_LOAD;
    endcase
  end

  // Sequencer outputs: store access, shared multiplier and divider operands.
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = load_cnt[IDX_W-1:0];
    ram_wdata = {pos_x, pos_y, phase};
    ram_raddr = j_cnt[IDX_W-1:0];
    mul_a     = '0;
    mul_b     = '0;
    div_num   = '0;
    div_den   = NORM2_W'(nr);
    is_div    = 1'b0;
    sq_start  = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        ram_we   = in_valid && !store_full;
      end
      ST_SELF_RD:  ram_raddr = i_idx;
      ST_SQ_X: begin
        mul_a = MUL_W'(dx);
        mul_b = MUL_W'(dx);
      end
      ST_SQ_Y: begin
        mul_a = MUL_W'(dy);
        mul_b = MUL_W'(dy);
      end
      ST_SQRT:     sq_start = !sq_busy && !sq_done;
      ST_TRIG_Z: begin
        mul_a = MUL_W'($signed({1'b0, z_comb}));
        mul_b = MUL_W'($signed({1'b0, z_comb}));
      end
      ST_TRIG_C: begin
        mul_a = MUL_W'($signed({1'b0, SIN_C}));
        mul_b = MUL_W'($signed({1'b0, prod_hi}));
      end
      ST_TRIG_B: begin
        mul_a = MUL_W'($signed({1'b0, SIN_B - prod_hi}));
        mul_b = MUL_W'($signed({1'b0, z2_reg}));
      end
      ST_TRIG_A: begin
        mul_a = MUL_W'($signed({1'b0, SIN_A - prod_hi}));
        mul_b = MUL_W'($signed({1'b0, z_reg}));
      end
      ST_W_MUL: begin
        mul_a = MUL_W'(coupling_gain);
        mul_b = MUL_W'(cos_v);
      end
      ST_DIV_UX: begin
        is_div  = 1'b1;
        div_num = NUM_W'(dx) <<< FRAC_W;
      end
      ST_DIV_UY: begin
        is_div  = 1'b1;
        div_num = NUM_W'(dy) <<< FRAC_W;
      end
      ST_DIV_RX: begin
        is_div  = 1'b1;
        div_num = NUM_W'(dx) <<< (2 * FRAC_W);
        div_den = norm2;
      end
      ST_DIV_RY: begin
        is_div  = 1'b1;
        div_num = NUM_W'(dy) <<< (2 * FRAC_W);
        div_den = norm2;
      end
      ST_DIV_PH: begin
        is_div  = 1'b1;
        div_num = NUM_W'(sin_v) <<< FRAC_W;
      end
      ST_M_UXW: begin
        mul_a = MUL_W'(ux);
        mul_b = MUL_W'(w);
      end
      ST_M_RX: begin
        mul_a = MUL_W'(repulse_gain);
        mul_b = MUL_W'(rx);
      end
      ST_M_UYW: begin
        mul_a = MUL_W'(uy);
        mul_b = MUL_W'(w);
      end
      ST_M_RY: begin
        mul_a = MUL_W'(repulse_gain);
        mul_b = MUL_W'(ry);
      end
      ST_DIV_MX: begin
        is_div  = 1'b1;
        div_num = sx;
        div_den = NORM2_W'(set_n);
      end
      ST_DIV_MY: begin
        is_div  = 1'b1;
        div_num = sy;
        div_den = NORM2_W'(set_n);
      end
      ST_DIV_MP: begin
        is_div  = 1'b1;
        div_num = sp;
        div_den = NORM2_W'(set_n);
      end
      ST_SYNC_MUL: begin
        mul_a = MUL_W'(sync_gain);
        mul_b = MUL_W'(mp);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign div_start = is_div && !div_busy && !div_done;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      load_cnt      <= '0;
      out_valid     <= 1'b0;
      attract_gain  <= 32'sd65536;
      coupling_gain <= '0;
      repulse_gain  <= 32'sd65536;
      sync_gain     <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ATTRACT:  attract_gain  <= cfg_data;
          CFG_COUPLING: coupling_gain <= cfg_data;
          CFG_REPULSE:  repulse_gain  <= cfg_data;
          CFG_SYNC:     sync_gain     <= cfg_data;
          default:      sync_gain     <= sync_gain;
        endcase
      end
      if (in_acc) begin
        if (last_in) begin
          load_cnt <= '0;
        end else if (!store_full) begin
          load_cnt <= load_cnt + CNT_W'(1);
        end
      end
      if (state == ST_PUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_full[PROD_W-1:0];
    case (state)
      ST_LOAD: begin
        if (in_acc && last_in) begin
          set_n <= store_full ? load_cnt : load_cnt + CNT_W'(1);
          i_idx <= '0;
        end
      end
      ST_SELF_CAP: begin
        self_x  <= rd_x;
        self_y  <= rd_y;
        self_ph <= rd_ph;
        sx      <= '0;
        sy      <= '0;
        sp      <= '0;
        coin    <= 1'b0;
        j_cnt   <= '0;
      end
      ST_PAIR_RD: begin
        if (j_cnt < set_n && j_is_self) begin
          j_cnt <= j_cnt + CNT_W'(1);
        end
      end
      ST_PAIR_DX: begin
        dx   <= DIFF_W'(rd_x) - DIFF_W'(self_x);
        dy   <= DIFF_W'(rd_y) - DIFF_W'(self_y);
        dphi <= rd_ph - self_ph;
      end
      ST_SQ_Y:  norm2 <= prod[NORM2_W-1:0];
      ST_NORM2: norm2 <= norm2 + prod[NORM2_W-1:0];
      ST_CHECK: begin
        if (norm2 == '0) begin
          coin  <= 1'b1;
          j_cnt <= j_cnt + CNT_W'(1);
        end
      end
      ST_SQRT: begin
        nr       <= sq_root;
        trig_sel <= 1'b0;
      end
      ST_TRIG_Z: begin
        z_reg    <= z_comb;
        trig_neg <= angle[PH_W-1];
      end
      ST_TRIG_C: z2_reg <= prod_hi;
      ST_TRIG_END: begin
        if (trig_sel) begin
          sin_v <= trig_val;
        end else begin
          cos_v    <= trig_val;
          trig_sel <= 1'b1;
        end
      end
      ST_W_SUM:  w <= WGT_W'(attract_gain) + $signed(prod_sh[WGT_W-1:0]);
      ST_DIV_UX: if (div_done) ux <= div_q[UNIT_W-1:0];
      ST_DIV_UY: if (div_done) uy <= div_q[UNIT_W-1:0];
      ST_DIV_RX: if (div_done) rx <= clamp32(div_q);
      ST_DIV_RY: if (div_done) ry <= clamp32(div_q);
      ST_DIV_PH: if (div_done) sp <= sp + NUM_W'(clamp32(div_q));
      ST_M_RX:   tx_a <= prod_sh;
      ST_M_UYW:  sx <= sx + tx_a - prod_sh;
      ST_M_RY:   ty_a <= prod_sh;
      ST_M_END: begin
        sy    <= sy + ty_a - prod_sh;
        j_cnt <= j_cnt + CNT_W'(1);
      end
      ST_DIV_MX:   if (div_done) mx <= clamp32(div_q);
      ST_DIV_MY:   if (div_done) my <= clamp32(div_q);
      ST_DIV_MP:   if (div_done) mp <= clamp32(div_q);
      ST_SYNC_END: pr <= clamp32(prod_sh);
      ST_PUT: begin
        if (out_free) begin
          vel_x      <= mx;
          vel_y      <= my;
          phase_rate <= pr;
          coincident <= coin;
          last_out   <= is_last_res;
          if (!is_last_res) begin
            i_idx <= i_idx + IDX_W'(1);
          end
        end
      end
      default: begin
        coin <= coin;
      end
    endcase
  end

  // A beat arriving at a full store is dropped and leaves the count alone.
  `SWPR_ASSERT_NEXT(a_full_drop, clk, rst, in_acc && !last_in && store_full,
                    load_cnt == CNT_W'(MAX_OSC))
  // Closing a set stops loading and starts on the first stored oscillator.
  `SWPR_ASSERT_NEXT(a_set_start, clk, rst, in_acc && last_in,
                    !in_ready && state == ST_SELF_RD)
  // An oscillator is never paired with itself.
  `SWPR_ASSERT_SAME(a_no_self_pair, clk, rst, state == ST_PAIR_DX, !j_is_self)

endmodule

>>> test/swpr_rates_checker.sv
// Checker for the swarmalator pairwise rates unit: watches the configuration,
// oscillator and result channels, predicts each set's rates and compares them.
// Depends on swpr_pkg for the register codes and widths.
`timescale 1ns / 1ps

module swpr_rates_checker import swpr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_index,
  input  logic [VAL_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [PH_W-1:0]         phase,
  input  logic                    last_in,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [VAL_W-1:0] vel_x,
  input  logic signed [VAL_W-1:0] vel_y,
  input  logic signed [VAL_W-1:0] phase_rate,
  input  logic                    coincident,
  input  logic                    last_out,
  output int                      fail_count,
  output int                      pending,
  output int                      rates_seen
);

  typedef struct packed {
    logic signed [VAL_W-1:0] vx;
    logic signed [VAL_W-1:0] vy;
    logic signed [VAL_W-1:0] pr;
    logic                    coin;
    logic                    last;
  } rates_t;

  rates_t      rates_due[$];
  longint      attract, coupling, repulse, sync_k;
  longint      xs [MAX_OSC];
  longint      ys [MAX_OSC];
  logic [15:0] phs [MAX_OSC];
  int          stored;

  assign pending = rates_due.size();

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint quarter_sine(input longint u);
    longint z, z2, t;
    z  = u * 4;
    z2 = (z * z) >> 16;
    t  = (longint'(SIN_C) * z2) >> 16;
    t  = longint'(SIN_B) - t;
    t  = (t * z2) >> 16;
    t  = longint'(SIN_A) - t;
    return (t * z) >> 16;
  endfunction

  function automatic longint turn_sine(input logic [15:0] a);
    longint u, s;
    u = longint'(a[13:0]);
    if (a[14]) u = 16384 - u;
    s = quarter_sine(u);
    return a[15] ? -s : s;
  endfunction

  // Works out every result of the set just closed and queues them in load order.
  task automatic predict_set();
    longint sx, sy, sp, dx, dy, n2, nr, w, ux, uy, rx, ry, sn;
    logic [15:0] dphi;
    logic coin;
    rates_t r;
    for (int i = 0; i < stored; i++) begin
      sx = 0; sy = 0; sp = 0; coin = 1'b0;
      for (int j = 0; j < stored; j++) begin
        if (j == i) continue;
        dx = xs[j] - xs[i];
        dy = ys[j] - ys[i];
        n2 = dx * dx + dy * dy;
        if (n2 == 0) begin
          coin = 1'b1;
          continue;
        end
        nr   = root_floor(n2);
        dphi = phs[j] - phs[i];
        w  = attract + ((coupling * turn_sine(dphi + QUARTER_TURN)) >>> 16);
        ux = (dx * 65536) / nr;
        uy = (dy * 65536) / nr;
        rx = sat32((dx * 64'sd4294967296) / n2);
        ry = sat32((dy * 64'sd4294967296) / n2);
        sx += ((ux * w) >>> 16) - ((repulse * rx) >>> 16);
        sy += ((uy * w) >>> 16) - ((repulse * ry) >>> 16);
        sp += sat32((turn_sine(dphi) * 65536) / nr);
      end
      sn = sat32(sp / stored);
      r.vx   = VAL_W'(sat32(sx / stored));
      r.vy   = VAL_W'(sat32(sy / stored));
      r.pr   = VAL_W'(sat32((sync_k * sn) >>> 16));
      r.coin = coin;
      r.last = (i + 1 == stored);
      rates_due.push_back(r);
    end
  endtask

  task automatic flag_mismatch(input string what, input rates_t want, input rates_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("rates %0d %s: expected vx=%0d vy=%0d pr=%0d coin=%0b last=%0b, got vx=%0d vy=%0d pr=%0d coin=%0b last=%0b",
               rates_seen, what, want.vx, want.vy, want.pr, want.coin, want.last,
               got.vx, got.vy, got.pr, got.coin, got.last);
  endtask

  initial begin
    fail_count = 0;
    rates_seen = 0;
  end

  always @(posedge clk) begin
    rates_t got, want;
    if (rst) begin
      attract  = 65536;
      coupling = 0;
      repulse  = 65536;
      sync_k   = 0;
      stored   = 0;
      rates_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_ATTRACT:  attract  = longint'($signed(cfg_data));
          CFG_COUPLING: coupling = longint'($signed(cfg_data));
          CFG_REPULSE:  repulse  = longint'($signed(cfg_data));
          CFG_SYNC:     sync_k   = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{vel_x, vel_y, phase_rate, coincident, last_out};
        if (rates_due.size() == 0) begin
          flag_mismatch("unexpected beat", '0, got);
        end else begin
          want = rates_due.pop_front();
          if (got !== want) flag_mismatch("field mismatch", want, got);
        end
        rates_seen++;
      end
      // A beat arriving with the store full is dropped, though its last flag still counts.
      if (in_valid && in_ready) begin
        if (stored < MAX_OSC) begin
          xs[stored]  = longint'(pos_x);
          ys[stored]  = longint'(pos_y);
          phs[stored] = phase;
          stored++;
        end
        if (last_in) begin
          predict_set();
          stored = 0;
        end
      end
    end
  end

endmodule

>>> test/tb_swarmalator_pairwise_rates_unit.sv
// Top of the swarmalator pairwise rates unit testbench: clock, reset, stimulus
// and verdict. Depends on swpr_pkg, the unit itself and swpr_rates_checker.
`timescale 1ns / 1ps

module tb_swarmalator_pairwise_rates_unit import swpr_pkg::*; ();

  localparam longint CYCLE_LIMIT = 40_000_000;
  localparam int     TARGET_OSC  = 380;
  localparam int     QUIET_FROM  = 340;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_valid, cfg_ready;
  logic [CFG_W-1:0]        cfg_index;
  logic [VAL_W-1:0]        cfg_data;
  logic                    in_valid, in_ready;
  logic signed [POS_W-1:0] pos_x, pos_y;
  logic [PH_W-1:0]         phase;
  logic                    last_in;
  logic                    out_valid, out_ready;
  logic signed [VAL_W-1:0] vel_x, vel_y, phase_rate;
  logic                    coincident, last_out;
  int                      fail_count, pending, rates_seen;

  bit     gaps_on;
  int     osc_sent, sets_sent, gain_sets, stall_left;
  longint cycles;

  swarmalator_pairwise_rates_unit i_dut (.*);
  swpr_rates_checker i_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("swarmalator_pairwise_rates_unit: mismatch");
      $finish;
    end
  end

  // Receiver back-pressure in bursts, switched off with the sender's gaps.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (gaps_on && !rst && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 14) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // Called at the step of the previous acceptance, so valid is raised or the
  // payload replaced with one assignment each.
  task automatic send_osc(input logic [23:0] x, input logic [23:0] y,
                          input logic [15:0] ph, input logic last);
    int gap;
    gap = (gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x    <= x;
    pos_y    <= y;
    phase    <= ph;
    last_in  <= last;
    do @(posedge clk); while (!in_ready);
    osc_sent++;
    if (last) sets_sent++;
  endtask

  // Stops sending and waits until every queued result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_gain(input cfg_reg_t idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_gains(input logic [31:0] a, input logic [31:0] c,
                                 input logic [31:0] r, input logic [31:0] s);
    drain();
    write_gain(CFG_ATTRACT, a);
    write_gain(CFG_COUPLING, c);
    write_gain(CFG_REPULSE, r);
    write_gain(CFG_SYNC, s);
    gain_sets++;
  endtask

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return '0;
      default: return 32'($signed($urandom_range(0, 524288)) - 262144);
    endcase
  endfunction

  function automatic logic [23:0] pick_pos();
    if ($urandom_range(0, 9) == 0) return 24'($urandom());
    return 24'($signed($urandom_range(0, 524288)) - 262144);
  endfunction

  initial begin
    logic [23:0] x, y, px, py;
    int n;
    rst = 1'b1; cycles = 0; stall_left = 0; gaps_on = 1'b1;
    osc_sent = 0; sets_sent = 0; gain_sets = 0;
    cfg_valid <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    in_valid <= 1'b0; pos_x <= '0; pos_y <= '0; phase <= '0; last_in <= 1'b0;
    out_ready <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_all_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0002_0000);
    // A lone oscillator gives all-zero rates.
    send_osc(24'h01_0000, 24'h02_0000, 16'h1234, 1'b1);
    // Two oscillators sharing a position.
    send_osc(24'h00_8000, 24'h00_8000, 16'h0000, 1'b0);
    send_osc(24'h00_8000, 24'h00_8000, 16'h4000, 1'b0);
    send_osc(24'hFF_0000, 24'h00_1000, 16'h8000, 1'b1);
    // Opposite corners of the position range.
    send_osc(24'h80_0000, 24'h80_0000, 16'h0000, 1'b0);
    send_osc(24'h7F_FFFF, 24'h7F_FFFF, 16'hFFFF, 1'b1);
    // Phases on and beside the quadrant boundaries.
    send_osc(24'h00_0000, 24'h00_0000, 16'h0000, 1'b0);
    send_osc(24'h01_0000, 24'h00_0000, 16'h4000, 1'b0);
    send_osc(24'h00_0000, 24'h01_0000, 16'h8000, 1'b0);
    send_osc(24'hFF_0000, 24'h00_0000, 16'hC000, 1'b0);
    send_osc(24'h00_0000, 24'hFF_0000, 16'h3FFF, 1'b1);
    write_all_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_osc(24'h00_0001, 24'h00_0000, 16'h0000, 1'b0);
    send_osc(24'h00_0000, 24'h00_0001, 16'hC000, 1'b0);
    send_osc(24'h00_0000, 24'h00_0000, 16'h8000, 1'b1);
    write_all_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_osc(24'h00_0001, 24'h00_0001, 16'h4000, 1'b0);
    send_osc(24'h00_0000, 24'h00_0000, 16'hFFFF, 1'b0);
    send_osc(24'hFF_FFFF, 24'h00_0002, 16'h0001, 1'b1);
    write_all_gains('0, '0, '0, '0);
    send_osc(24'h12_3456, 24'hED_CBA9, 16'h5555, 1'b0);
    send_osc(24'hED_CBA9, 24'h12_3456, 16'hAAAA, 1'b1);

    // A full store: two further beats are dropped, the last one still closes the set.
    write_all_gains(32'h0001_8000, 32'hFFFF_0000, 32'h0000_2000, 32'h0000_C000);
    for (int k = 0; k < MAX_OSC + 2; k++)
      send_osc(pick_pos(), pick_pos(), 16'($urandom()), k == MAX_OSC + 1);

    while (osc_sent < TARGET_OSC) begin
      if (osc_sent >= QUIET_FROM) gaps_on = 1'b0;
      else gaps_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0)
        write_all_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain());
      else if ($urandom_range(0, 9) == 0)
        drain();
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
      for (int k = 0; k < n; k++) begin
        x = pick_pos();
        y = pick_pos();
        // Now and then reuse the previous position to make a coincident pair.
        if (k > 0 && $urandom_range(0, 7) == 0) begin
          x = px;
          y = py;
        end
        send_osc(x, y, 16'($urandom()), k == n - 1);
        px = x;
        py = y;
      end
    end
    drain();
    repeat (100) @(posedge clk);

    $display("sent %0d oscillator beats in %0d sets under %0d gain settings", osc_sent,
             sets_sent, gain_sets);
    $display("checked %0d rate beats, including a full store with dropped beats", rates_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("swarmalator_pairwise_rates_unit: match");
    end else begin
      $display("swarmalator_pairwise_rates_unit: mismatch");
    end
    $finish;
  end

endmodule
